// ===== rtl/core/porm_pkg.sv =====
// Shared types and constants for the pattern occurrence remover.
// No dependencies; imported by every module of the block.
package porm_pkg;

    localparam int MAX_PATTERN   = 4;
    localparam int NUM_PAT_WORDS = 4;
    localparam int WORD_W        = 32;
    localparam int CNT_W         = 16;
    localparam int LEN_W         = 3;
    localparam int CFG_ADDR_W    = 3;
    localparam int FILL_W        = $clog2(MAX_PATTERN + 1);
    localparam int QDEPTH        = 4;
    localparam int QPTR_W        = $clog2(QDEPTH);
    localparam int QCNT_W        = $clog2(QDEPTH + 1);

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_LENGTH = 3'd0,
        REG_WORD_0 = 3'd1,
        REG_WORD_1 = 3'd2,
        REG_WORD_2 = 3'd3,
        REG_WORD_3 = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              eos;
    } in_item_t;

    typedef struct packed {
        logic [FILL_W-1:0]                          len;
        logic [NUM_PAT_WORDS-1:0][WORD_W-1:0]       pattern;
    } cfg_t;

    typedef struct packed {
        logic [FILL_W-1:0] fill;
        logic              last_pending;
        logic              pop;
    } back_stat_t;

endpackage

// ===== rtl/core/porm_cfg.sv =====
// Configuration register file: pattern length and pattern words.
// Depends on porm_pkg; feeds the effective length and pattern to porm_back.
module porm_cfg
    import porm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [WORD_W-1:0]     cfg_data,
    output cfg_t                  cfg
);

    logic [LEN_W-1:0]  length_reg;
    logic [WORD_W-1:0] words_reg [NUM_PAT_WORDS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            length_reg <= LEN_W'(1);
            for (int i = 0; i < NUM_PAT_WORDS; i++) begin
                words_reg[i] <= '0;
            end
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                REG_LENGTH: length_reg   <= cfg_data[LEN_W-1:0];
                REG_WORD_0: words_reg[0] <= cfg_data;
                REG_WORD_1: words_reg[1] <= cfg_data;
                REG_WORD_2: words_reg[2] <= cfg_data;
                REG_WORD_3: words_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // length 0 acts as 1, anything above the window depth is clamped
    always_comb begin
        if (length_reg == '0) begin
            cfg.len = FILL_W'(1);
        end else if (32'(length_reg) > MAX_PATTERN) begin
            cfg.len = FILL_W'(MAX_PATTERN);
        end else begin
            cfg.len = FILL_W'(length_reg);
        end
        for (int i = 0; i < NUM_PAT_WORDS; i++) begin
            cfg.pattern[i] = words_reg[i];
        end
    end

endmodule

// ===== rtl/core/porm_queue.sv =====
// Short word queue between the input side and the window engine.
// Depends on porm_pkg.
module porm_queue
    import porm_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_item,
    output logic     out_valid,
    input  logic     out_ready,
    output in_item_t out_item
);

    in_item_t           mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               push, pop;

    assign in_ready  = (count_reg != QCNT_W'(QDEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== rtl/core/porm_back.sv =====
// Window engine: appends queued words, compares against the pattern, drains
// and flushes, and holds the output register. Depends on porm_pkg.
module porm_back
    import porm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  cfg_t              cfg,
    input  logic              q_valid,
    output logic              q_ready,
    input  in_item_t          q_item,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [WORD_W-1:0] m_word,
    output logic              m_carries,
    output logic [CNT_W-1:0]  m_count,
    output logic              m_final,
    output back_stat_t        stat
);

    logic [WORD_W-1:0] win_reg  [MAX_PATTERN];
    logic [WORD_W-1:0] win_next [MAX_PATTERN];
    logic [WORD_W-1:0] ext      [MAX_PATTERN];
    logic [WORD_W-1:0] sh1      [MAX_PATTERN];
    logic [WORD_W-1:0] shl      [MAX_PATTERN];
    logic [FILL_W-1:0] fill_reg, fill_next, ext_fill;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              lp_reg, lp_next;
    logic              advance, do_flush, pop, iterate, match;
    logic              emit, e_carries, e_final;
    logic [WORD_W-1:0] e_word;

    logic              out_valid_reg;
    logic [WORD_W-1:0] out_word_reg;
    logic              out_carries_reg, out_final_reg;
    logic [CNT_W-1:0]  out_count_reg;

    assign advance  = !out_valid_reg || m_ready;
    assign do_flush = lp_reg && (fill_reg < cfg.len);
    assign pop      = advance && !lp_reg && (fill_reg < cfg.len) && q_valid;
    assign ext_fill = fill_reg + FILL_W'(pop);
    // a window left over-full by a shorter length drains only once a word waits or a final word is pending
    assign iterate  = advance && !do_flush && (ext_fill >= cfg.len) && (q_valid || lp_reg);
    assign q_ready  = pop;

    // window with the incoming word placed after the valid entries
    always_comb begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
            ext[i] = (pop && fill_reg == FILL_W'(i)) ? q_item.word : win_reg[i];
        end
    end

    always_comb begin
        logic [WORD_W-1:0] p;
        p     = '0;
        match = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (i < NUM_PAT_WORDS) begin
                p = cfg.pattern[i];
            end else begin
                p = '0;
            end
            if (FILL_W'(i) < cfg.len && ext[i] != p) begin
                match = 1'b0;
            end
        end
    end

    // shifted windows: drop one word, or drop a whole match
    always_comb begin
        int j;
        j = 0;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            sh1[i] = (i + 1 < MAX_PATTERN) ? ext[(i + 1) % MAX_PATTERN] : ext[i];
            j = i + int'(cfg.len);
            shl[i] = ext[i];
            for (int k = 0; k < MAX_PATTERN; k++) begin
                if (j == k) begin
                    shl[i] = ext[k];
                end
            end
        end
    end

    always_comb begin
        win_next  = win_reg;
        fill_next = fill_reg;
        cnt_next  = cnt_reg;
        lp_next   = lp_reg;
        emit      = 1'b0;
        e_word    = '0;
        e_carries = 1'b0;
        e_final   = 1'b0;
        priority if (advance && do_flush) begin
            emit = 1'b1;
            if (fill_reg != '0) begin
                e_word    = ext[0];
                e_carries = 1'b1;
                win_next  = sh1;
                fill_next = fill_reg - FILL_W'(1);
            end else begin
                // terminator: carries the count, then the sequence restarts
                e_final  = 1'b1;
                cnt_next = '0;
                lp_next  = 1'b0;
            end
        end else if (iterate) begin
            if (match) begin
                win_next  = shl;
                fill_next = ext_fill - cfg.len;
                if (cnt_reg != '1) begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end else begin
                emit      = 1'b1;
                e_word    = ext[0];
                e_carries = 1'b1;
                win_next  = sh1;
                fill_next = ext_fill - FILL_W'(1);
            end
            if (pop) begin
                lp_next = q_item.eos;
            end
        end else if (pop) begin
            win_next  = ext;
            fill_next = ext_fill;
            lp_next   = q_item.eos;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg      <= '0;
            cnt_reg       <= '0;
            lp_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            fill_reg <= fill_next;
            cnt_reg  <= cnt_next;
            lp_reg   <= lp_next;
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        win_reg <= win_next;
        if (emit) begin
            out_word_reg    <= e_word;
            out_carries_reg <= e_carries;
            out_final_reg   <= e_final;
            out_count_reg   <= cnt_reg;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_word    = out_word_reg;
    assign m_carries = out_carries_reg;
    assign m_count   = out_count_reg;
    assign m_final   = out_final_reg;

    assign stat.fill         = fill_reg;
    assign stat.last_pending = lp_reg;
    assign stat.pop          = pop;

endmodule

// ===== rtl/core/pattern_occurrence_remover.sv =====
// Top level of the pattern occurrence remover.
// Depends on porm_pkg, porm_cfg, porm_queue and porm_back.
//
// Usage:
//   s_ channel: one input word per handshake; s_tlast marks the final word
//   of a sequence. m_ channel: surviving words in order, then a terminator
//   word (m_tlast high, carries_word low) holding the match count.
//   cfg channel: register index on cfg_addr (0 length, 1..4 pattern words),
//   data on cfg_data; always ready. Write only while the block is idle.
// Path: once the window holds pattern_length words, a surviving word is
//   presented on m_ after the word that completes the window is accepted: the
//   queue takes that word at the accepting edge, and the window engine then
//   loads the surviving word into the output register.
// Throughput: one word per cycle while m_tready holds and no flush is owed, set by
//   the single window compare per cycle. A final word is followed by a flush of the
//   words still in the window, then the terminator; after a shortened pattern
//   length the next word drains the window one step per cycle while m_tready holds.
// Reset: pattern length 1, pattern words 0, window empty, count zero.
// Receiver stall: the output register holds its word, the engine halts and
//   the four-entry queue keeps accepting until full, then s_tready drops.
module pattern_occurrence_remover
    import porm_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [WORD_W-1:0]         s_tdata,   // [31:0] word_in
    input  logic                      s_tlast,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [WORD_W+CNT_W-1:0]   m_tdata,   // [31:0] word_out, [47:32] matches_removed
    output logic                      m_tuser,   // [0] carries_word
    output logic                      m_tlast,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [WORD_W-1:0]         cfg_data
);

    cfg_t              cfg;
    in_item_t          s_item, q_item;
    logic              q_valid, q_ready;
    logic [WORD_W-1:0] m_word;
    logic [CNT_W-1:0]  m_count;
    back_stat_t        stat;

    assign s_item.word = s_tdata;
    assign s_item.eos  = s_tlast;

    porm_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    porm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (s_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    porm_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_word    (m_word),
        .m_carries (m_tuser),
        .m_count   (m_count),
        .m_final   (m_tlast),
        .stat      (stat)
    );

    assign m_tdata = {m_count, m_word};

    // window never holds more words than it has entries
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(stat.fill) <= MAX_PATTERN)
        else $error("window fill above depth");

    // terminator carries no word
    a_term_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> !m_tuser && (m_tdata[WORD_W-1:0] == '0))
        else $error("terminator with word payload");

    // no new word enters the window while a flush is owed
    a_no_pop_in_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        !(stat.pop && stat.last_pending))
        else $error("word taken during flush");

endmodule
